>>> hw/rtl/pose_differentiating_velocity_estimator_assert.svh
// Assertion macros shared by the velocity estimator modules.
`ifndef POSE_DIFFERENTIATING_VELOCITY_ESTIMATOR_ASSERT_SVH
`define POSE_DIFFERENTIATING_VELOCITY_ESTIMATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PDVE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PDVE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pdve_pkg.sv
// Package with types and constants of the pose velocity estimator.
package pdve_pkg;

    localparam int unsigned PiQ13    = 25736;
    localparam int unsigned TwoPiQ13 = 51472;
    localparam logic [35:0] PiQ30    = 36'd3373259426;
    localparam logic [31:0] OneQ30   = 32'd1073741824;
    localparam logic [31:0] GapMinReset = 32'd1000;
    localparam logic [31:0] GapMaxReset = 32'd200000;
    localparam logic [19:0] UsPerSec = 20'd1000000;
    localparam logic [22:0] RateScale = 23'd8000000;

    // Register indexes on the configuration port.
    localparam logic [0:0] RegGapMin = 1'b0;
    localparam logic [0:0] RegGapMax = 1'b1;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_SETUP,
        t_ST_ITER,
        t_ST_FIX,
        t_ST_DIV,
        t_ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic iter;
        logic fix;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gated;
        logic iter_last;
        logic div_last;
    } t_sts;

    // Q30 arctangent table for the CORDIC.
    function automatic logic [35:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0: v = 32'd843314857;
                5'd1: v = 32'd497837829;
                5'd2: v = 32'd263043837;
                5'd3: v = 32'd133525159;
                5'd4: v = 32'd67021687;
                5'd5: v = 32'd33543516;
                5'd6: v = 32'd16775851;
                5'd7: v = 32'd8388437;
                5'd8: v = 32'd4194283;
                5'd9: v = 32'd2097149;
                5'd31: v = 32'd0;
                default: v = 32'd1 << (5'd30 - i);
            endcase
            atan_q30 = {4'd0, v};
        end
    endfunction

endpackage

>>> hw/rtl/pdve_if.sv
// Valid/ready stream interface used for both sample and result channels.
interface pdve_if #(
    parameter int unsigned WIDTH = 32
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pdve_ctrl.sv
// Controller state machine sequencing the velocity datapath.
`include "pose_differentiating_velocity_estimator_assert.svh"

module pdve_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  pdve_pkg::t_sts  i_sts,
    output pdve_pkg::t_cmd  o_cmd
);

    pdve_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdve_pkg::t_ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdve_pkg::t_ST_IDLE: begin
                if (i_in_valid) n_state = pdve_pkg::t_ST_SETUP;
            end
            pdve_pkg::t_ST_SETUP: begin
                n_state = i_sts.gated ? pdve_pkg::t_ST_ITER : pdve_pkg::t_ST_DONE;
            end
            pdve_pkg::t_ST_ITER: begin
                if (i_sts.iter_last) n_state = pdve_pkg::t_ST_FIX;
            end
            pdve_pkg::t_ST_FIX: n_state = pdve_pkg::t_ST_DIV;
            pdve_pkg::t_ST_DIV: begin
                if (i_sts.div_last) n_state = pdve_pkg::t_ST_DONE;
            end
            pdve_pkg::t_ST_DONE: begin
                if (i_out_ready) n_state = pdve_pkg::t_ST_IDLE;
            end
            default: n_state = pdve_pkg::t_ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            pdve_pkg::t_ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            pdve_pkg::t_ST_SETUP: o_cmd.setup = 1'b1;
            pdve_pkg::t_ST_ITER: o_cmd.iter = 1'b1;
            pdve_pkg::t_ST_FIX: begin
                o_cmd.fix = 1'b1;
                o_cmd.div_start = 1'b1;
            end
            pdve_pkg::t_ST_DIV: o_cmd.div_step = 1'b1;
            pdve_pkg::t_ST_DONE: begin
                o_out_valid = 1'b1;
                o_cmd.finish = i_out_ready;
            end
            default: ;
        endcase
    end

    `PDVE_ASSERT_IMPL(a_ready_excl, i_clk, i_rst_n, o_in_ready, !o_out_valid, "ready while result held")
    `PDVE_ASSERT_NEXT(a_load_setup, i_clk, i_rst_n, o_cmd.load, r_state == pdve_pkg::t_ST_SETUP, "load not followed by setup")
    `PDVE_ASSERT_NEXT(a_done_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped")

endmodule

>>> hw/rtl/pdve_dp.sv
// Datapath: square root, CORDIC, speed and yaw-rate dividers and sample state.
`include "pose_differentiating_velocity_estimator_assert.svh"

module pdve_dp #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdve_pkg::t_cmd     i_cmd,
    output pdve_pkg::t_sts     o_sts,
    input  logic [31:0]        i_gap_min,
    input  logic [31:0]        i_gap_max,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  logic [31:0]        i_time,
    output logic [30:0]        o_speed,
    output logic signed [31:0] o_yaw_rate,
    output logic               o_rates_valid
);
    localparam int unsigned Steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // Sample state.
    logic signed [31:0] r_prev_x, r_prev_y;
    logic signed [15:0] r_prev_yaw;
    logic [31:0]        r_prev_time;
    logic               r_have_prev;

    // Working registers.
    logic [31:0]        r_gap;
    logic               r_valid;
    logic signed [32:0] r_qmul_a, r_qmul_b;
    logic signed [35:0] r_cx, r_cy, r_cz;
    logic [63:0]        r_rem, r_root, r_bit;
    logic               r_sh;
    logic [4:0]         r_iter;
    logic [6:0]         r_div_cnt;
    logic [52:0]        r_dnum_s, r_dq_s;
    logic [53:0]        r_drem_s;
    logic [43:0]        r_dnum_y, r_dq_y;
    logic [44:0]        r_drem_y;
    logic               r_yneg;

    // Delta magnitudes.
    logic signed [32:0] dx, dy;
    logic [32:0]        ax, ay, hx, hy;
    logic               big;
    always_comb begin
        dx = 33'(i_pos_x) - 33'(r_prev_x);
        dy = 33'(i_pos_y) - 33'(r_prev_y);
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        ay = dy[32] ? 33'(-dy) : 33'(dy);
        big = ax[31] | ax[32] | ay[31] | ay[32];
        hx = big ? (ax >> 1) : ax;
        hy = big ? (ay >> 1) : ay;
    end

    // CORDIC start vector: numerator and denominator of the heading, both Q30.
    logic signed [35:0] num_c, den_c;
    always_comb begin
        num_c = 36'(r_qmul_a) <<< 1;
        den_c = 36'(pdve_pkg::OneQ30) - (36'(r_qmul_b) <<< 1);
    end

    // One CORDIC rotation and one root digit a cycle.
    logic signed [35:0] xs, ys, cx_n, cy_n, cz_n;
    logic [63:0] rb;
    always_comb begin
        xs = r_cx >>> r_iter;
        ys = r_cy >>> r_iter;
        if (!r_cy[35]) begin
            cx_n = r_cx + ys; cy_n = r_cy - xs; cz_n = r_cz + pdve_pkg::atan_q30(r_iter);
        end else begin
            cx_n = r_cx - ys; cy_n = r_cy + xs; cz_n = r_cz - pdve_pkg::atan_q30(r_iter);
        end
        rb = r_root + r_bit;
    end

    // Yaw rounding and wrap.
    logic signed [35:0] zr;
    logic signed [35:0] yraw;
    logic signed [15:0] yaw_c;
    logic signed [17:0] dyaw;
    logic [16:0]        adyaw;
    always_comb begin
        zr = (r_cz + 36'sd65536) >>> 17;
        if (r_cx == 0 && r_cy == 0) yraw = '0;
        else yraw = zr;
        if (yraw > 36'sd25736) yaw_c = 16'sd25736;
        else if (yraw < -36'sd25736) yaw_c = -16'sd25736;
        else yaw_c = 16'(yraw);
        dyaw = 18'(yaw_c) - 18'(r_prev_yaw);
        if (dyaw > 18'sd25736) dyaw = dyaw - 18'sd51472;
        else if (dyaw < -18'sd25736) dyaw = dyaw + 18'sd51472;
        adyaw = dyaw[17] ? 17'(-dyaw) : 17'(dyaw);
    end

    // Restoring division steps.
    logic [53:0] ts;
    logic [44:0] ty;
    always_comb begin
        ts = {r_drem_s[52:0], r_dnum_s[52]};
        ty = {r_drem_y[43:0], r_dnum_y[43]};
    end

    logic [31:0] gap_c;
    logic gated;
    assign gap_c = i_time - r_prev_time;
    assign gated = r_have_prev && (gap_c > i_gap_min) && (gap_c < i_gap_max);
    assign o_sts.gated = r_valid;
    assign o_sts.iter_last = (r_iter == 5'(Steps - 1));
    assign o_sts.div_last = (r_div_cnt == 7'd77);

    // Sample state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0; r_prev_y <= '0; r_prev_yaw <= '0;
            r_prev_time <= '0; r_have_prev <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev_x <= i_pos_x; r_prev_y <= i_pos_y;
                r_prev_time <= i_time; r_have_prev <= 1'b1;
            end
            if (i_cmd.fix) r_prev_yaw <= yaw_c;
        end
    end

    // Working datapath.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_valid <= gated;
            r_gap <= gap_c;
            r_sh <= big;
            r_rem <= 64'(hx[30:0]) * 64'(hx[30:0]) + 64'(hy[30:0]) * 64'(hy[30:0]);
            r_root <= '0;
            r_bit <= 64'd1 << 62;
            r_qmul_a <= 33'(i_quat_w) * 33'(i_quat_z) + 33'(i_quat_x) * 33'(i_quat_y);
            r_qmul_b <= 33'(i_quat_y) * 33'(i_quat_y) + 33'(i_quat_z) * 33'(i_quat_z);
            r_iter <= '0;
        end
        if (i_cmd.setup) begin
            // Pre-rotate a negative x by pi.
            if (den_c[35]) begin
                r_cx <= -den_c;
                r_cy <= -num_c;
                r_cz <= r_qmul_a[32] ? -$signed(pdve_pkg::PiQ30) : $signed(pdve_pkg::PiQ30);
            end else begin
                r_cx <= den_c;
                r_cy <= num_c;
                r_cz <= '0;
            end
        end
        if (i_cmd.iter) begin
            r_cx <= cx_n; r_cy <= cy_n; r_cz <= cz_n;
            r_iter <= r_iter + 5'd1;
        end
        // Root: two radicand bits (one root bit) per step over the CORDIC and the first divider cycles.
        if (i_cmd.iter || i_cmd.div_step) begin
            if (r_bit != 0) begin
                if (r_rem >= rb) begin
                    r_rem <= r_rem - rb; r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
        if (i_cmd.fix) begin
            r_yneg <= dyaw[17];
            r_dnum_y <= 44'(adyaw) * 44'(pdve_pkg::RateScale);
            r_drem_y <= '0; r_dq_y <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (r_div_cnt == 7'd24) begin
                // Root has had its 32 steps by now; load the speed dividend.
                r_dnum_s <= 53'(r_sh ? {r_root[31:0], 1'b0} : {1'b0, r_root[31:0]})
                            * 53'(pdve_pkg::UsPerSec);
                r_drem_s <= '0; r_dq_s <= '0;
            end else if (r_div_cnt > 7'd24) begin
                r_dnum_s <= r_dnum_s << 1;
                if (ts >= 54'(r_gap)) begin
                    r_drem_s <= ts - 54'(r_gap); r_dq_s <= {r_dq_s[51:0], 1'b1};
                end else begin
                    r_drem_s <= ts; r_dq_s <= {r_dq_s[51:0], 1'b0};
                end
            end
            if (r_div_cnt < 7'd44) begin
                r_dnum_y <= r_dnum_y << 1;
                if (ty >= 45'(r_gap)) begin
                    r_drem_y <= ty - 45'(r_gap); r_dq_y <= {r_dq_y[42:0], 1'b1};
                end else begin
                    r_drem_y <= ty; r_dq_y <= {r_dq_y[42:0], 1'b0};
                end
            end
            r_div_cnt <= r_div_cnt + 7'd1;
        end
    end

    // Saturation of the quotients (speed divider ends on its last step).
    logic [52:0] sq;
    assign sq = r_dq_s;
    always_comb begin
        o_rates_valid = r_valid;
        if (!r_valid) begin
            o_speed = '0; o_yaw_rate = '0;
        end else begin
            o_speed = (sq > 53'h7FFFFFFF) ? 31'h7FFFFFFF : sq[30:0];
            if (r_yneg) o_yaw_rate = (r_dq_y > 44'h80000000) ? 32'sh80000000
                                     : 32'(-$signed({1'b0, r_dq_y[31:0]}));
            else o_yaw_rate = (r_dq_y > 44'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(r_dq_y[31:0]);
        end
    end

    `PDVE_ASSERT_NEXT(a_have_prev, i_clk, i_rst_n, i_cmd.load, r_have_prev, "have_prev not set")
    `PDVE_ASSERT_IMPL(a_gate, i_clk, i_rst_n, i_cmd.iter, r_valid, "cordic ran outside gate")
    `PDVE_ASSERT_IMPL(a_yaw_rng, i_clk, i_rst_n, i_cmd.fix, yaw_c <= 16'sd25736 && yaw_c >= -16'sd25736, "yaw out of range")

endmodule

>>> hw/rtl/pose_differentiating_velocity_estimator.sv
// Top level of the pose differentiating velocity estimator.
// Outside the gate a sample goes from setup straight to the result state. Inside it, the
// CORDIC steps, a fix state and the divider steps follow (root, then a 53-step division).
// Throughput: one sample at a time; the next is taken the cycle after the result transfer.
// Reset (synchronous, active low) clears sample history and loads the default gap limits.
module pose_differentiating_velocity_estimator #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdve_if.sink        i_sample,
    pdve_if.source      o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] r_gap_min, r_gap_max;
    pdve_pkg::t_cmd cmd;
    pdve_pkg::t_sts sts;
    logic [30:0] speed;
    logic signed [31:0] yaw_rate;
    logic rates_valid;

    assign pready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_min <= pdve_pkg::GapMinReset;
            r_gap_max <= pdve_pkg::GapMaxReset;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                pdve_pkg::RegGapMin: r_gap_min <= pwdata;
                pdve_pkg::RegGapMax: r_gap_max <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (paddr[2])
            pdve_pkg::RegGapMin: prdata = r_gap_min;
            pdve_pkg::RegGapMax: prdata = r_gap_max;
            default: prdata = '0;
        endcase
    end

    pdve_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_sample.valid), .o_in_ready(i_sample.ready),
        .o_out_valid(o_result.valid), .i_out_ready(o_result.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    pdve_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_sts(sts),
        .i_gap_min(r_gap_min), .i_gap_max(r_gap_max),
        .i_pos_x(i_sample.payload[159:128]),
        .i_pos_y(i_sample.payload[127:96]),
        .i_quat_x(i_sample.payload[95:80]),
        .i_quat_y(i_sample.payload[79:64]),
        .i_quat_z(i_sample.payload[63:48]),
        .i_quat_w(i_sample.payload[47:32]),
        .i_time(i_sample.payload[31:0]),
        .o_speed(speed), .o_yaw_rate(yaw_rate), .o_rates_valid(rates_valid)
    );

    assign o_result.payload = {speed, yaw_rate, rates_valid};

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the pose differentiating velocity estimator.
`timescale 1ns / 100ps

module tb_top;

    localparam int SampleW = 160;
    localparam int ResultW = 64;
    localparam int CordicSteps = 16;
    localparam int SettleCycles = 4 + CordicSteps + 78 + 8;
    localparam int StallLimit = 6000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic [31:0]        sample_time_us;
    } t_sample;

    typedef struct packed {
        logic [30:0]        speed;
        logic signed [31:0] yaw_rate;
        logic               rates_valid;
    } t_rates;

    localparam longint AtanQ30 [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1, 0};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pdve_if #(.WIDTH(SampleW)) smp_if ();
    pdve_if #(.WIDTH(ResultW)) res_if ();

    pose_differentiating_velocity_estimator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if.sink),
        .o_result (res_if.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow state of the estimator.
    logic [31:0]        gap_min;
    logic [31:0]        gap_max;
    logic signed [31:0] last_x;
    logic signed [31:0] last_y;
    logic signed [15:0] last_yaw;
    logic [31:0]        last_time;
    logic               seen_sample;

    t_rates expected_rates[$];
    int     src_idle_pct;
    int     snk_stall_pct;
    int     hold_off_cycles;
    int     error_count;
    int     quiet_cycles;
    logic [31:0] now_us;
    logic signed [31:0] walk_x;
    logic signed [31:0] walk_y;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Heading in Q3.13 from the CORDIC vectoring of (x, y).
    function automatic longint heading_q13(input longint y, input longint x);
        longint z;
        longint xs;
        longint ys;
        longint r;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y < 0) ? -64'sd3373259426 : 64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CordicSteps; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + AtanQ30[i];
            end else begin
                x = x - ys; y = y + xs; z = z - AtanQ30[i];
            end
        end
        r = (z + 65536) >>> 17;
        if (r > 25736) r = 25736;
        if (r < -25736) r = -25736;
        return r;
    endfunction

    // Speed and yaw rate for one sample; updates the shadow history.
    function automatic t_rates estimate_rates(input t_sample s);
        t_rates o;
        logic [31:0] gap;
        longint dx, dy, num, den, yaw, dyaw, rate;
        longint unsigned a, b, span, spd;
        int sh;
        o = '0;
        gap = s.sample_time_us - last_time;
        o.rates_valid = seen_sample && gap > gap_min && gap < gap_max;
        if (o.rates_valid) begin
            dx = longint'(s.pos_x) - longint'(last_x);
            dy = longint'(s.pos_y) - longint'(last_y);
            a = (dx < 0) ? -dx : dx;
            b = (dy < 0) ? -dy : dy;
            sh = 0;
            if (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
                a = a >> 1; b = b >> 1; sh = 1;
            end
            span = int_sqrt(a * a + b * b) << sh;
            spd = span * 1000000 / {32'd0, gap};
            if (spd > 64'h7FFF_FFFF) spd = 64'h7FFF_FFFF;
            o.speed = spd[30:0];
            num = 2 * (longint'(s.quat_w) * s.quat_z + longint'(s.quat_x) * s.quat_y);
            den = 64'sd1073741824
                - 2 * (longint'(s.quat_y) * s.quat_y + longint'(s.quat_z) * s.quat_z);
            yaw = heading_q13(num, den);
            dyaw = yaw - longint'(last_yaw);
            if (dyaw > 25736) dyaw = dyaw - 51472;
            else if (dyaw < -25736) dyaw = dyaw + 51472;
            rate = dyaw * 8000000 / longint'({32'd0, gap});
            if (rate > 64'sd2147483647) rate = 64'sd2147483647;
            if (rate < -64'sd2147483648) rate = -64'sd2147483648;
            o.yaw_rate = rate[31:0];
            last_yaw = yaw[15:0];
        end
        last_x = s.pos_x;
        last_y = s.pos_y;
        last_time = s.sample_time_us;
        seen_sample = 1'b1;
        return o;
    endfunction

    // Sends one sample and records its expected rates.
    task automatic send_sample(input t_sample s);
        @(negedge i_clk);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid   <= 1'b1;
        smp_if.payload <= s;
        expected_rates.push_back(estimate_rates(s));
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic wait_drained();
        stop_sending();
        while (expected_rates.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Register write over the configuration port.
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == pdve_pkg::RegGapMin) gap_min = val;
        else gap_max = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_gate(input logic [31:0] lo, input logic [31:0] hi);
        wait_drained();
        write_reg(pdve_pkg::RegGapMin, lo);
        write_reg(pdve_pkg::RegGapMax, hi);
    endtask

    function automatic t_sample pose_at(input logic [31:0] gap, input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic [63:0] quat);
        t_sample s;
        now_us = now_us + gap;
        s.pos_x = x;
        s.pos_y = y;
        {s.quat_x, s.quat_y, s.quat_z, s.quat_w} = quat;
        s.sample_time_us = now_us;
        return s;
    endfunction

    // Random sample, mostly inside the gate with a short walk in position.
    function automatic t_sample random_sample();
        logic [31:0] gap;
        logic [63:0] q;
        int pick;
        pick = $urandom_range(99);
        if (pick < 80 && gap_max > gap_min + 1) begin
            gap = $urandom_range(gap_max - 1, gap_min + 1);
        end else if (pick < 88) begin
            gap = $urandom_range(2) ? gap_min : gap_max;
        end else begin
            gap = $urandom;
        end
        if ($urandom_range(9) == 0) begin
            walk_x = $urandom;
            walk_y = $urandom;
        end else begin
            walk_x = walk_x + $signed($urandom_range(2097151)) - 1048576;
            walk_y = walk_y + $signed($urandom_range(2097151)) - 1048576;
        end
        q = {$urandom, $urandom};
        return pose_at(gap, walk_x, walk_y, q);
    endfunction

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !(snk_stall_pct > 0 && $urandom_range(99) < snk_stall_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_rates got;
        t_rates want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.payload;
            if (expected_rates.size() == 0) begin
                $error("result transfer with no sample outstanding: %h", got);
                error_count++;
            end else begin
                want = expected_rates.pop_front();
                if (got.speed !== want.speed) begin
                    $error("speed: expected %0d, got %0d", want.speed, got.speed);
                    error_count++;
                end
                if (got.yaw_rate !== want.yaw_rate) begin
                    $error("yaw_rate: expected %0d, got %0d", want.yaw_rate, got.yaw_rate);
                    error_count++;
                end
                if (got.rates_valid !== want.rates_valid) begin
                    $error("rates_valid: expected %0b, got %0b",
                           want.rates_valid, got.rates_valid);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // First sample, reset yaw history, quaternion corner cases, extremes and time wrap.
    task automatic test_directed();
        send_sample(pose_at(32'd0, 32'sd0, 32'sd0, 64'h0000_0000_0000_7FFF));
        send_sample(pose_at(32'd5000, 32'sd65536, 32'sd131072, 64'h0000_0000_2D41_2D41));
        // Degenerate heading: both CORDIC inputs zero.
        send_sample(pose_at(32'd5000, 32'sd70000, -32'sd5, 64'h0000_4000_4000_0000));
        // Negative x axis: pre-rotation by pi, with a zero y component.
        send_sample(pose_at(32'd5000, 32'sd0, 32'sd0, 64'h0000_0000_8000_0000));
        send_sample(pose_at(32'd5000, 32'sd0, 32'sd0, 64'h0100_0000_8000_0000));
        send_sample(pose_at(32'd5000, 32'sd0, 32'sd0, 64'hFF00_0000_8000_0000));
        // Largest position swing in both directions.
        send_sample(pose_at(32'd1001, 32'h8000_0000, 32'h7FFF_FFFF, 64'h8000_8000_8000_8000));
        send_sample(pose_at(32'd1001, 32'h7FFF_FFFF, 32'h8000_0000, 64'h7FFF_7FFF_7FFF_7FFF));
        send_sample(pose_at(32'd199999, 32'hFFFF_FFFF, 32'h0000_0001, 64'h5A82_0000_0000_A57E));
        // Gate edges: gap equal to each limit.
        send_sample(pose_at(32'd1000, 32'sd1, 32'sd1, 64'h0000_0000_7FFF_0000));
        send_sample(pose_at(32'd200000, 32'sd2, 32'sd2, 64'h0000_0000_8001_0000));
        send_sample(pose_at(32'd1500, 32'sd3, 32'sd3, 64'h0000_0000_7FFF_0000));
        // Time counter wrapping across zero.
        now_us = 32'hFFFF_FF00;
        send_sample(pose_at(32'd0, 32'sd10, 32'sd10, 64'h0000_0000_0000_7FFF));
        send_sample(pose_at(32'd4000, 32'sd20, 32'sd20, 64'h0000_0000_1000_7000));
        send_sample(pose_at(32'd0, 32'sd20, 32'sd20, 64'h0000_0000_1000_7000));
    endtask

    // Register extremes, including empty gates.
    task automatic test_gate_settings();
        set_gate(32'd0, 32'hFFFF_FFFF);
        send_sample(pose_at(32'd1, 32'sd5, 32'sd5, 64'h1234_5678_9ABC_DEF0));
        send_sample(pose_at(32'hFFFF_FFFE, 32'sd9, 32'sd1, 64'hFEDC_BA98_7654_3210));
        send_sample(pose_at(32'd0, 32'sd9, 32'sd1, 64'hFEDC_BA98_7654_3210));
        set_gate(32'hFFFF_FFFF, 32'd0);
        for (int i = 0; i < 4; i++) send_sample(random_sample());
        set_gate(32'd100, 32'd101);
        send_sample(pose_at(32'd100, 32'sd1, 32'sd1, 64'd0));
        send_sample(pose_at(32'd101, 32'sd1, 32'sd1, 64'd0));
        set_gate(32'd0, 32'd2);
        send_sample(pose_at(32'd1, 32'sd7, 32'sd7, 64'h0000_0000_3000_6000));
        send_sample(pose_at(32'd1, 32'h7FFF_0000, 32'sd7, 64'h0000_0000_C000_6000));
        set_gate(32'd10, 32'd400000);
        for (int i = 0; i < 20; i++) send_sample(random_sample());
    endtask

    task automatic test_random(input int n, input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int i = 0; i < n; i++) begin
            send_sample(random_sample());
            if (i == n / 2) wait_drained();
        end
    endtask

    // Long receiver hold-off while samples keep being offered.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_off_cycles = 400;
        for (int i = 0; i < 20; i++) send_sample(random_sample());
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        smp_if.valid = 1'b0;
        smp_if.payload = '0;
        res_if.ready = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_off_cycles = 0;
        error_count = 0;
        quiet_cycles = 0;
        now_us = 32'd0;
        walk_x = 32'sd0;
        walk_y = 32'sd0;
        gap_min = pdve_pkg::GapMinReset;
        gap_max = pdve_pkg::GapMaxReset;
        last_x = '0;
        last_y = '0;
        last_yaw = '0;
        last_time = '0;
        seen_sample = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_gate_settings();
        set_gate(pdve_pkg::GapMinReset, pdve_pkg::GapMaxReset);
        test_random(180, 0, 0);
        test_backpressure();
        test_random(150, 82, 0);
        test_random(150, 0, 82);
        test_random(150, 13, 13);

        wait_drained();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
